[rtl/ncdf_pkg.sv]
`timescale 1ns / 1ps
package ncdf_pkg;

	localparam int QF = 28;
	localparam int IN_FRAC_BITS_DEF = 12;
	localparam int OUT_BITS_DEF = 16;
	localparam int EXP_TERMS = 14;
	localparam int POW_STEPS = 31;
	localparam int DIV_STEPS = QF + 1;
	localparam int HORNER_STEPS = 5;

	localparam logic [63:0] Q_HALF64 = 64'd1 << (QF - 1);
	localparam logic [28:0] Q_ONE = 29'd1 << QF;
	localparam logic [35:0] X_CLAMP = 36'd9 << QF;

	// decimal constant in units of 1e-9 to Q28, round half up
	function automatic logic [31:0] from_nano(input logic [63:0] n);
		return 32'((n * (64'd1 << QF) + 64'd500000000) / 64'd1000000000);
	endfunction

	localparam logic signed [31:0] K_A1 = $signed(from_nano(64'd254829592));
	localparam logic signed [31:0] K_A2 = 32'sd0 - $signed(from_nano(64'd284496736));
	localparam logic signed [31:0] K_A3 = $signed(from_nano(64'd1421413741));
	localparam logic signed [31:0] K_A4 = 32'sd0 - $signed(from_nano(64'd1453152027));
	localparam logic signed [31:0] K_A5 = $signed(from_nano(64'd1061405429));
	localparam logic [31:0] K_P = from_nano(64'd327591100);
	localparam logic [31:0] K_RSQRT2 = from_nano(64'd707106781);

	localparam logic signed [31:0] K_HORNER [HORNER_STEPS] = '{K_A4, K_A3, K_A2, K_A1, 32'sd0};

	// floor(2^31 / k) for k = 14 down to 1
	localparam logic [31:0] EXP_RECIP [EXP_TERMS] = '{
		32'(64'd2147483648 / 64'd14), 32'(64'd2147483648 / 64'd13),
		32'(64'd2147483648 / 64'd12), 32'(64'd2147483648 / 64'd11),
		32'(64'd2147483648 / 64'd10), 32'(64'd2147483648 / 64'd9),
		32'(64'd2147483648 / 64'd8), 32'(64'd2147483648 / 64'd7),
		32'(64'd2147483648 / 64'd6), 32'(64'd2147483648 / 64'd5),
		32'(64'd2147483648 / 64'd4), 32'(64'd2147483648 / 64'd3),
		32'(64'd2147483648 / 64'd2), 32'(64'd2147483648 / 64'd1)
	};

	// exp(-1) from the same rounded series the datapath uses
	function automatic logic [27:0] exp_neg_one();
		logic [63:0] s;
		logic [63:0] qm;
		logic [63:0] term;
		s = 64'd1 << QF;
		for (int k = EXP_TERMS; k >= 1; k--) begin
			qm = ((64'd1 << QF) * s + Q_HALF64) >> QF;
			term = (qm + 64'(k / 2)) / 64'(k);
			s = (term >= (64'd1 << QF)) ? 64'd0 : (64'd1 << QF) - term;
		end
		return 28'(s);
	endfunction

	localparam logic [27:0] EINV = exp_neg_one();

	typedef struct packed {
		logic        neg;
		logic [33:0] w;
		logic [29:0] d;
		logic [29:0] rem;
		logic [28:0] q;
	} div_t;

	typedef struct packed {
		logic               neg;
		logic [33:0]        w;
		logic [28:0]        t;
		logic signed [31:0] acc;
	} hn_t;

	typedef struct packed {
		logic        neg;
		logic [27:0] f;
		logic [5:0]  n;
		logic [29:0] acc;
		logic [28:0] s;
		logic [28:0] x;
		logic [28:0] q0;
	} ex_t;

	typedef struct packed {
		logic        neg;
		logic [5:0]  n;
		logic [29:0] acc;
		logic [28:0] r;
	} pw_t;

endpackage

[rtl/normal_cdf_erf_approx.sv]
`timescale 1ns / 1ps
// channel | signals                      | direction
// x       | x_valid x_ready x_value[15:0] | in  (Q4.12 signed argument)
// cdf     | cdf_valid cdf_ready cdf_value | out (Phi(x), unsigned Q0.OUT_BITS)
// One word per cycle; the pipe holds the 29-step reciprocal divider, the
// 14-level exp series (three stages each) and 31 stages of exp(-1) products.
// Reset clears only the valid bits. All stages advance together when the
// output register is empty or being taken, so a stall freezes the pipe.
module normal_cdf_erf_approx
	import ncdf_pkg::*;
#(
	parameter int IN_FRAC_BITS = IN_FRAC_BITS_DEF,
	parameter int OUT_BITS = OUT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                x_valid,
	output logic                x_ready,
	input  logic signed [15:0]  x_value,
	output logic                cdf_valid,
	input  logic                cdf_ready,
	output logic [OUT_BITS-1:0] cdf_value
);

	localparam int SH = QF - IN_FRAC_BITS;
	localparam int P_DIV0 = 4;
	localparam int P_HN0 = P_DIV0 + DIV_STEPS;
	localparam int P_EX0 = P_HN0 + HORNER_STEPS;
	localparam int P_PW0 = P_EX0 + 3 * EXP_TERMS;
	localparam int P_F1 = P_PW0 + POW_STEPS;
	localparam int P_OUT = P_F1 + 1;
	localparam int NSTG = P_OUT + 1;
	localparam logic [30:0] MAXV = (31'd1 << OUT_BITS) - 31'd1;
	localparam logic [30:0] RND = 31'd1 << (QF - OUT_BITS);
	localparam logic [OUT_BITS-1:0] HALF_OUT = OUT_BITS'(1) << (OUT_BITS - 1);

	logic adv;
	logic [NSTG-1:0] vld_s;

	assign adv = !vld_s[P_OUT] || cdf_ready;
	assign x_ready = adv;
	assign cdf_valid = vld_s[P_OUT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[NSTG-2:0], x_valid};
		end
	end

	// stage 1: magnitude, scale to Q28, clamp at 9
	logic        neg_s1;
	logic [31:0] a_s1;
	logic [15:0] mag;
	logic [35:0] a_ext;

	always_comb begin
		mag = x_value[15] ? (16'd0 - 16'(x_value)) : 16'(x_value);
		a_ext = 36'(mag) << SH;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s1 <= x_value[15];
			a_s1 <= (a_ext > X_CLAMP) ? X_CLAMP[31:0] : a_ext[31:0];
		end
	end

	// stage 2: z = a / sqrt2
	logic        neg_s2;
	logic [30:0] z_s2;
	logic [63:0] zp;

	assign zp = 64'(a_s1) * 64'(K_RSQRT2) + Q_HALF64;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s2 <= neg_s1;
			z_s2 <= zp[58:28];
		end
	end

	// stage 3: d = 1 + p*z, and partial products of z*z
	logic        neg_s3;
	logic [33:0] unused_pad;
	logic [29:0] d_s3;
	logic [29:0] hh_s3;
	logic [30:0] hl_s3;
	logic [31:0] ll_s3;
	logic [63:0] pzp;

	assign pzp = 64'(K_P) * 64'(z_s2) + Q_HALF64;
	assign unused_pad = '0;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_s3 <= neg_s2;
			d_s3 <= 30'(Q_ONE) + pzp[57:28];
			hh_s3 <= 30'(z_s2[30:16]) * 30'(z_s2[30:16]);
			hl_s3 <= 31'(z_s2[30:16]) * 31'(z_s2[15:0]);
			ll_s3 <= 32'(z_s2[15:0]) * 32'(z_s2[15:0]);
		end
	end

	// stage 4: w = z*z, divider seed
	div_t        dv_s4;
	logic [63:0] wp;

	assign wp = (64'(hh_s3) << 32) + (64'(hl_s3) << 17) + 64'(ll_s3) + Q_HALF64
		+ 64'(unused_pad);

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_s4.neg <= neg_s3;
			dv_s4.w <= wp[61:28];
			dv_s4.d <= d_s3;
			dv_s4.rem <= 30'd1 << (QF - 1);
			dv_s4.q <= '0;
		end
	end

	// t = round(2^56 / d), one quotient bit per stage
	div_t dv_s [DIV_STEPS];

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
		div_t        din;
		div_t        dnx;
		logic [30:0] rsh;
		logic        ge;
		if (j == 0) begin : g_first
			assign din = dv_s4;
		end else begin : g_next
			assign din = dv_s[j-1];
		end
		always_comb begin
			dnx = din;
			rsh = {din.rem, din.d[DIV_STEPS-j]};
			ge = rsh >= {1'b0, din.d};
			dnx.rem = ge ? 30'(rsh - {1'b0, din.d}) : rsh[29:0];
			dnx.q = {din.q[27:0], ge};
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_s[j] <= dnx;
			end
		end
	end

	// Horner in signed Q28, products rounded half away from zero
	hn_t hn_s [HORNER_STEPS];

	for (genvar h = 0; h < HORNER_STEPS; h++) begin : g_hn
		hn_t                hin;
		hn_t                hnx;
		logic [31:0]        hmag;
		logic [63:0]        hp;
		logic [31:0]        hr;
		logic signed [31:0] hsum;
		if (h == 0) begin : g_first
			always_comb begin
				hin.neg = dv_s[DIV_STEPS-1].neg;
				hin.w = dv_s[DIV_STEPS-1].w;
				hin.t = dv_s[DIV_STEPS-1].q;
				hin.acc = K_A5;
			end
		end else begin : g_next
			assign hin = hn_s[h-1];
		end
		always_comb begin
			hnx = hin;
			hmag = hin.acc[31] ? (32'd0 - 32'(hin.acc)) : 32'(hin.acc);
			hp = 64'(hmag) * 64'(hin.t) + Q_HALF64;
			hr = hp[59:28];
			hsum = (hin.acc[31] ? (32'sd0 - $signed(hr)) : $signed(hr)) + K_HORNER[h];
			if (h == HORNER_STEPS - 1 && hsum[31]) begin
				hsum = 32'sd0;
			end
			hnx.acc = hsum;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				hn_s[h] <= hnx;
			end
		end
	end

	// exp(-f): one series level per three stages (multiply, reciprocal, fix-up)
	ex_t ea_s [EXP_TERMS];
	ex_t eb_s [EXP_TERMS];
	ex_t ec_s [EXP_TERMS];

	for (genvar l = 0; l < EXP_TERMS; l++) begin : g_exp
		localparam int KK = EXP_TERMS - l;
		localparam int KHALF = KK / 2;
		ex_t         ein;
		ex_t         enx_a;
		ex_t         enx_b;
		ex_t         enx_c;
		logic [63:0] pa;
		logic [63:0] pb;
		logic [32:0] rm;
		logic [28:0] qv;
		if (l == 0) begin : g_first
			always_comb begin
				ein.neg = hn_s[HORNER_STEPS-1].neg;
				ein.f = hn_s[HORNER_STEPS-1].w[27:0];
				ein.n = hn_s[HORNER_STEPS-1].w[33:28];
				ein.acc = hn_s[HORNER_STEPS-1].acc[29:0];
				ein.s = Q_ONE;
				ein.x = '0;
				ein.q0 = '0;
			end
		end else begin : g_next
			assign ein = ec_s[l-1];
		end
		always_comb begin
			enx_a = ein;
			pa = 64'(ein.f) * 64'(ein.s) + Q_HALF64;
			enx_a.x = pa[56:28] + 29'(KHALF);
		end
		always_comb begin
			enx_b = ea_s[l];
			pb = 64'(ea_s[l].x) * 64'(EXP_RECIP[l]);
			enx_b.q0 = pb[59:31];
		end
		// reciprocal estimate is at most one low
		always_comb begin
			enx_c = eb_s[l];
			rm = 33'(eb_s[l].x) - 33'(eb_s[l].q0) * 33'(KK);
			qv = eb_s[l].q0 + 29'(rm >= 33'(KK));
			enx_c.s = (qv >= Q_ONE) ? 29'd0 : Q_ONE - qv;
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				ea_s[l] <= enx_a;
				eb_s[l] <= enx_b;
				ec_s[l] <= enx_c;
			end
		end
	end

	// multiply by exp(-1) once per unit of the integer part
	pw_t pw_s [POW_STEPS];

	for (genvar i = 0; i < POW_STEPS; i++) begin : g_pow
		pw_t         pin;
		pw_t         pnx;
		logic [63:0] pp;
		if (i == 0) begin : g_first
			always_comb begin
				pin.neg = ec_s[EXP_TERMS-1].neg;
				pin.n = ec_s[EXP_TERMS-1].n;
				pin.acc = ec_s[EXP_TERMS-1].acc;
				pin.r = ec_s[EXP_TERMS-1].s;
			end
		end else begin : g_next
			assign pin = pw_s[i-1];
		end
		always_comb begin
			pnx = pin;
			pp = 64'(pin.r) * 64'(EINV) + Q_HALF64;
			if (6'(i) < pin.n) begin
				pnx.r = pp[56:28];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				pw_s[i] <= pnx;
			end
		end
	end

	// poly * exp
	logic        neg_sf;
	logic [30:0] pe_sf;
	logic [28:0] exv;
	logic [63:0] pep;

	always_comb begin
		exv = pw_s[POW_STEPS-1].n[5] ? 29'd0 : pw_s[POW_STEPS-1].r;
		pep = 64'(pw_s[POW_STEPS-1].acc) * 64'(exv) + Q_HALF64;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_sf <= pw_s[POW_STEPS-1].neg;
			pe_sf <= pep[58:28];
		end
	end

	// erf, Phi in Q29, round and saturate
	logic        neg_so;
	logic [28:0] ev;
	logic [29:0] vv;
	logic [30:0] rs;
	logic [30:0] sh;

	always_comb begin
		ev = (pe_sf >= 31'(Q_ONE)) ? 29'd0 : 29'(31'(Q_ONE) - pe_sf);
		vv = neg_sf ? (30'(Q_ONE) - 30'(ev)) : (30'(Q_ONE) + 30'(ev));
		rs = 31'(vv) + RND;
		sh = rs >> (QF + 1 - OUT_BITS);
		if (sh > MAXV) begin
			sh = MAXV;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_so <= neg_sf;
			cdf_value <= sh[OUT_BITS-1:0];
		end
	end

	a_neg_half: assert property (@(posedge clk) disable iff (!arst_n)
		cdf_valid && neg_so |-> cdf_value <= HALF_OUT)
		else $error("negative argument gave Phi above one half");

	a_pos_half: assert property (@(posedge clk) disable iff (!arst_n)
		cdf_valid && !neg_so |-> cdf_value >= HALF_OUT)
		else $error("nonnegative argument gave Phi below one half");

	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[P_HN0-1] |-> dv_s[DIV_STEPS-1].rem < dv_s[DIV_STEPS-1].d)
		else $error("divider remainder not below divisor");

	a_exp_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[P_F1-1] |-> pw_s[POW_STEPS-1].r <= Q_ONE)
		else $error("exp result above one");

endmodule

[tb/sv/normal_cdf_erf_approx_tb.sv]
`timescale 1ns / 1ps
module normal_cdf_erf_approx_tb;
	import ncdf_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES = 250;
	localparam int HOLD_CYCLES = 500;
	localparam int N_RANDOM = 1625;

	typedef struct {
		logic [15:0] x;
		bit          typed;
		logic [15:0] cdf;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        x_valid;
	logic        x_ready;
	logic signed [15:0] x_value;
	logic        cdf_valid;
	logic        cdf_ready;
	logic [15:0] cdf_value;

	logic [15:0] cdf_expected_q[$];
	int          errors;
	int          stall_count;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          rx_hold_req;

	normal_cdf_erf_approx dut (
		.clk(clk), .arst_n(arst_n),
		.x_valid(x_valid), .x_ready(x_ready), .x_value(x_value),
		.cdf_valid(cdf_valid), .cdf_ready(cdf_ready), .cdf_value(cdf_value)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Q28 product, rounded half up
	function automatic logic [63:0] q28_mul(logic [63:0] a, logic [63:0] b);
		return (a * b + (64'd1 << 27)) >> 28;
	endfunction

	function automatic longint q28_mul_signed(longint a, logic [63:0] b);
		logic [63:0] m;
		m = q28_mul((a < 0) ? 64'(-a) : 64'(a), b);
		return (a < 0) ? -longint'(m) : longint'(m);
	endfunction

	// exp(-f), f in [0, 1] Q28, series evaluated inside out
	function automatic logic [63:0] exp_series(logic [63:0] f);
		logic [63:0] s;
		logic [63:0] term;
		s = 64'd1 << 28;
		for (int k = 14; k >= 1; k--) begin
			term = (q28_mul(f, s) + 64'(k / 2)) / 64'(k);
			s = (term >= (64'd1 << 28)) ? 64'd0 : (64'd1 << 28) - term;
		end
		return s;
	endfunction

	function automatic logic [15:0] phi_predict(logic [15:0] raw);
		logic [63:0] one;
		logic [63:0] mag, a, z, d, t, w, ex, e1, pe, e, v, res;
		longint      acc;
		bit          neg;
		one = 64'd1 << 28;
		neg = raw[15];
		mag = neg ? 64'h10000 - 64'(raw) : 64'(raw);
		a = mag << (28 - 12);
		if (a > (64'd9 << 28))
			a = 64'd9 << 28;
		z = q28_mul(a, 64'(K_RSQRT2));
		d = one + q28_mul(64'(K_P), z);
		t = ((64'd1 << 56) + d / 2) / d;
		acc = longint'(K_A5);
		acc = q28_mul_signed(acc, t) + longint'(K_A4);
		acc = q28_mul_signed(acc, t) + longint'(K_A3);
		acc = q28_mul_signed(acc, t) + longint'(K_A2);
		acc = q28_mul_signed(acc, t) + longint'(K_A1);
		acc = q28_mul_signed(acc, t);
		if (acc < 0)
			acc = 0;
		w = q28_mul(z, z);
		if ((w >> 28) >= 32) begin
			ex = 0;
		end else begin
			ex = exp_series(w & (one - 1));
			e1 = exp_series(one);
			for (int i = 0; i < int'(w >> 28); i++)
				ex = q28_mul(ex, e1);
		end
		pe = q28_mul(64'(acc), ex);
		e = (pe >= one) ? 64'd0 : one - pe;
		v = neg ? one - e : one + e;
		res = (v + (64'd1 << 12)) >> 13;
		if (res > 64'hFFFF)
			res = 64'hFFFF;
		return res[15:0];
	endfunction

	task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	// one word offered and held until taken; expectation queued on acceptance
	task automatic send_word(logic [15:0] x, bit typed, logic [15:0] want);
		@(negedge clk);
		if ($urandom_range(99) < tx_idle_pct) begin
			x_valid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		x_valid <= 1'b1;
		x_value <= x;
		do @(posedge clk); while (!x_ready);
		cdf_expected_q.push_back(typed ? want : phi_predict(x));
	endtask

	function automatic logic [15:0] random_arg();
		case ($urandom_range(3))
			0: return 16'($urandom_range(65535));
			1: return 16'($urandom_range(4095));
			2: return 16'd0 - 16'($urandom_range(1, 16383));
			default: return 16'($urandom_range(16383));
		endcase
	endfunction

	// receiver side
	initial begin
		cdf_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_req) begin
				cdf_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				rx_hold_req = 1'b0;
			end
			cdf_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && cdf_valid && cdf_ready) begin
			if (cdf_expected_q.size() == 0) begin
				report_mismatch("cdf_value with no word pending", cdf_value, '0);
			end else if (cdf_value !== cdf_expected_q[0]) begin
				report_mismatch("cdf_value", cdf_value, cdf_expected_q.pop_front());
			end else begin
				void'(cdf_expected_q.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((x_valid && x_ready) || (cdf_valid && cdf_ready) || !arst_n)
			stall_count <= 0;
		else
			stall_count <= stall_count + 1;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("[normal_cdf_erf_approx] ERROR");
			$finish;
		end
	end

	initial begin
		stim_row_t rows[$];
		int n;
		errors = 0;
		stall_count = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		rx_hold_req = 1'b0;
		x_valid = 1'b0;
		x_value = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero, largest both ways, tiny, near the clamp, series boundaries
		rows.push_back('{16'h0000, 1, 16'd32768});
		rows.push_back('{16'h7FFF, 1, 16'd65535});
		rows.push_back('{16'h8000, 1, 16'd0});
		rows.push_back('{16'h8001, 0, 0});
		rows.push_back('{16'h0001, 0, 0});
		rows.push_back('{16'hFFFF, 0, 0});
		rows.push_back('{16'h1000, 0, 0});
		rows.push_back('{16'hF000, 0, 0});
		rows.push_back('{16'h16A1, 0, 0});
		rows.push_back('{16'hE95F, 0, 0});
		rows.push_back('{16'h2000, 0, 0});
		rows.push_back('{16'hE000, 0, 0});
		rows.push_back('{16'h4000, 0, 0});
		rows.push_back('{16'hC000, 0, 0});
		rows.push_back('{16'h5555, 0, 0});
		rows.push_back('{16'hAAAA, 0, 0});
		rows.push_back('{16'h0800, 0, 0});
		rows.push_back('{16'hF800, 0, 0});
		rows.push_back('{16'h6000, 0, 0});
		rows.push_back('{16'h9000, 0, 0});
		foreach (rows[i])
			send_word(rows[i].x, rows[i].typed, rows[i].cdf);

		for (int ph = 0; ph < 3; ph++) begin
			tx_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 85 : 0;
			rx_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 23 : 0;
			n = (ph == 2) ? N_RANDOM - 2 * (N_RANDOM / 3) : N_RANDOM / 3;
			for (int i = 0; i < n; i++) begin
				if (ph == 2 && i == 50)
					rx_hold_req = 1'b1;  // pipe fills, input must stall
				if (ph == 2 && i == 400) begin
					x_valid <= 1'b0;
					wait (cdf_expected_q.size() == 0);
				end
				send_word(random_arg(), 0, 0);
			end
		end
		@(negedge clk);
		x_valid <= 1'b0;
		wait (cdf_expected_q.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[normal_cdf_erf_approx] OK");
		else
			$display("[normal_cdf_erf_approx] ERROR");
		$finish;
	end

endmodule
